>>> sv/svacc_pkg.sv
// Shared types, constants and fixed-point helpers of the spring vertex accelerator.
`default_nettype none
package svacc_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_AXES_DEF  = 3;
  localparam int NUM_AXES      = 3;
  localparam int SCALAR_BITS   = 31;
  localparam int ACC_BITS      = 48;
  localparam int QDEPTH        = 2;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_DIMENSIONS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXT_X      = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXT_Y      = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXT_Z      = 2'd3;

  localparam logic signed [65:0] WMAX = (66'sd1 <<< (WORD_BITS - 1)) - 66'sd1;
  localparam logic signed [65:0] WMIN = -WMAX - 66'sd1;
  localparam logic signed [65:0] AMAX = (66'sd1 <<< (ACC_BITS - 1)) - 66'sd1;
  localparam logic signed [65:0] AMIN = -AMAX - 66'sd1;

  typedef enum logic {
    KIND_VERTEX   = 1'b0,
    KIND_NEIGHBOR = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t                                kind;
    logic [NUM_AXES-1:0][WORD_BITS-1:0]        pos;
    logic [NUM_AXES-1:0][WORD_BITS-1:0]        vel;
    logic [SCALAR_BITS-1:0]                    scalar_one;
    logic [SCALAR_BITS-1:0]                    scalar_two;
    logic                                      last;
  } qentry_t;

  typedef struct packed {
    logic [1:0]                                dims;
    logic [NUM_AXES-1:0][WORD_BITS-1:0]        ext;
  } cfg_t;

  typedef struct packed {
    logic                                      start;
    logic [63:0]                               dividend;
    logic [WORD_BITS-1:0]                      divisor;
  } div_req_t;

  typedef struct packed {
    logic                                      done;
    logic [63:0]                               quotient;
  } div_rsp_t;

  function automatic logic signed [65:0] signed_of(input logic neg, input logic [63:0] m);
    logic signed [65:0] v;
    v = $signed({2'b00, m});
    return neg ? -v : v;
  endfunction

  function automatic logic [WORD_BITS-1:0] sat_word(input logic signed [65:0] v);
    logic signed [65:0] r;
    r = v;
    if (v > WMAX) r = WMAX;
    else if (v < WMIN) r = WMIN;
    return r[WORD_BITS-1:0];
  endfunction

  function automatic logic [ACC_BITS-1:0] sat_acc(input logic signed [65:0] v);
    logic signed [65:0] r;
    r = v;
    if (v > AMAX) r = AMAX;
    else if (v < AMIN) r = AMIN;
    return r[ACC_BITS-1:0];
  endfunction

  function automatic logic [WORD_BITS-1:0] mag_word(input logic [WORD_BITS-1:0] v);
    return v[WORD_BITS-1] ? (~v + 1'b1) : v;
  endfunction

endpackage
`default_nettype wire

>>> sv/svacc_front.sv
// Input side: accepts items, tags them by kind and queues them for the sequencer.
`default_nettype none
module svacc_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               func,
  input  wire logic [svacc_pkg::WORD_BITS-1:0]    p_x,
  input  wire logic [svacc_pkg::WORD_BITS-1:0]    p_y,
  input  wire logic [svacc_pkg::WORD_BITS-1:0]    p_z,
  input  wire logic [svacc_pkg::WORD_BITS-1:0]    vel_x,
  input  wire logic [svacc_pkg::WORD_BITS-1:0]    vel_y,
  input  wire logic [svacc_pkg::WORD_BITS-1:0]    vel_z,
  input  wire logic [svacc_pkg::SCALAR_BITS-1:0]  scalar_one,
  input  wire logic [svacc_pkg::SCALAR_BITS-1:0]  scalar_two,
  input  wire logic                               last_item,
  output logic                                    q_valid,
  output svacc_pkg::qentry_t                      q_entry,
  input  wire logic                               q_pop
);

  localparam int PW = (svacc_pkg::QDEPTH > 1) ? $clog2(svacc_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(svacc_pkg::QDEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(svacc_pkg::QDEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(svacc_pkg::QDEPTH);

  svacc_pkg::qentry_t slots [svacc_pkg::QDEPTH];
  svacc_pkg::qentry_t entry_in;
  logic [PW-1:0]      wr_ptr;
  logic [PW-1:0]      rd_ptr;
  logic [CW-1:0]      count;
  logic               push;
  logic               pop;

  always_comb begin
    entry_in.kind       = func ? svacc_pkg::KIND_NEIGHBOR : svacc_pkg::KIND_VERTEX;
    entry_in.pos        = {p_z, p_y, p_x};
    entry_in.vel        = {vel_z, vel_y, vel_x};
    entry_in.scalar_one = scalar_one;
    entry_in.scalar_two = scalar_two;
    entry_in.last       = last_item;
  end

  assign in_ready = (count != CNT_FULL);
  assign q_valid  = (count != '0);
  assign q_entry  = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> sv/svacc_divu.sv
// Restoring unsigned divider, 64-bit dividend by word divisor, one quotient bit per cycle.
`default_nettype none
module svacc_divu (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire svacc_pkg::div_req_t   req,
  output svacc_pkg::div_rsp_t        rsp
);

  localparam int W = svacc_pkg::WORD_BITS;

  logic          busy;
  logic          done;
  logic [5:0]    cnt;
  logic [W-1:0]  rem;
  logic [63:0]   quo;
  logic [W-1:0]  dvsr;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;
  logic          ge;

  always_comb begin
    rem_sh = {rem, quo[63]};
    diff   = rem_sh - {1'b0, dvsr};
    ge     = (rem_sh >= {1'b0, dvsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quo  <= req.dividend;
      dvsr <= req.divisor;
    end else if (busy) begin
      rem <= ge ? diff[W-1:0] : rem_sh[W-1:0];
      quo <= {quo[62:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

>>> sv/svacc_back.sv
// Sequencer: per-item spring force accumulation and final acceleration, output register.
`default_nettype none
module svacc_back #(
  parameter int FRAC_BITS = svacc_pkg::FRAC_BITS_DEF,
  parameter int MAX_AXES  = svacc_pkg::MAX_AXES_DEF
) (
  input  wire logic                                              clk,
  input  wire logic                                              rst,
  input  wire logic                                              q_valid,
  input  wire svacc_pkg::qentry_t                                q_entry,
  output logic                                                   q_pop,
  input  wire svacc_pkg::cfg_t                                   cfg,
  output svacc_pkg::div_req_t                                    div_req,
  input  wire svacc_pkg::div_rsp_t                               div_rsp,
  output logic                                                   out_valid,
  input  wire logic                                              out_ready,
  output logic [svacc_pkg::NUM_AXES-1:0][svacc_pkg::WORD_BITS-1:0] out_accel,
  output logic [svacc_pkg::NUM_AXES-1:0][svacc_pkg::WORD_BITS-1:0] out_force,
  output logic                                                   out_fault
);

  localparam int W  = svacc_pkg::WORD_BITS;
  localparam int NA = svacc_pkg::NUM_AXES;
  localparam int SB = svacc_pkg::SCALAR_BITS;
  localparam int AB = svacc_pkg::ACC_BITS;
  localparam logic signed [65:0] LIM  = (66'sd1 <<< (63 - FRAC_BITS)) - 66'sd1;
  localparam logic [63:0]        QCAP = 64'd1 << (W - 1);
  localparam logic [1:0]         AXES_CAP = 2'(MAX_AXES);
  localparam logic [1:0]         K_LAST   = 2'(NA - 1);

  typedef enum logic [17:0] {
    ST_IDLE    = 18'b000000000000000001,
    ST_DIFF    = 18'b000000000000000010,
    ST_SQ      = 18'b000000000000000100,
    ST_SQACC   = 18'b000000000000001000,
    ST_SQRT    = 18'b000000000000010000,
    ST_STR     = 18'b000000000000100000,
    ST_TSAT    = 18'b000000000001000000,
    ST_FMUL    = 18'b000000000010000000,
    ST_FSTART  = 18'b000000000100000000,
    ST_FDIV    = 18'b000000001000000000,
    ST_LASTCHK = 18'b000000010000000000,
    ST_DMUL    = 18'b000000100000000000,
    ST_NUM     = 18'b000001000000000000,
    ST_QSTART  = 18'b000010000000000000,
    ST_QDIV    = 18'b000100000000000000,
    ST_OUT     = 18'b001000000000000000,
    ST_SPARE0  = 18'b010000000000000000,
    ST_SPARE1  = 18'b100000000000000000
  } state_t;

  state_t state;

  // vertex data
  logic [NA-1:0][W-1:0]  vpos;
  logic [NA-1:0][W-1:0]  vvel;
  logic [SB-1:0]         vmass;
  logic [SB-1:0]         vdamp;
  logic [NA-1:0][AB-1:0] fsum;
  logic                  fault_seen;

  // item in flight
  logic [NA-1:0][W-1:0]  npos;
  logic [SB-1:0]         nstiff;
  logic [SB-1:0]         nrest;
  logic                  cur_last;

  logic [NA-1:0][W-1:0]  d_mag;
  logic [NA-1:0]         d_neg;
  logic [63:0]           sumsq;
  logic [34:0]           sq_rem;
  logic [W-1:0]          sq_root;
  logic [63:0]           sq_src;
  logic [4:0]            sq_cnt;
  logic                  str_neg;
  logic [W-1:0]          t_mag;
  logic                  t_neg;
  logic [1:0]            k;
  logic [63:0]           prod;
  logic                  num_neg;
  logic [63:0]           num_mag;
  logic [NA-1:0][W-1:0]  res_a;
  logic [NA-1:0][W-1:0]  res_f;

  logic [1:0]            dims_eff;
  logic                  k_active;
  logic [W-1:0]          mul_a;
  logic [W-1:0]          mul_b;
  logic [W-1:0]          stretch_mag;
  logic                  stretch_neg;
  logic [34:0]           sq_rem_sh;
  logic [34:0]           sq_trial;
  logic                  sq_ge;
  logic [W-1:0]          vel_mag;
  logic [W-1:0]          t_val;
  logic signed [65:0]    num_raw;
  logic signed [65:0]    num_cl;
  logic signed [65:0]    f_val;
  logic [63:0]           q_cap;
  logic [W-1:0]          qs_word;
  logic [W-1:0]          accel_word;
  logic                  out_free;
  logic                  out_load;

  always_comb begin
    dims_eff = (cfg.dims == 2'd0) ? 2'd1 : cfg.dims;
    if (dims_eff > AXES_CAP) dims_eff = AXES_CAP;
  end

  assign k_active = (k < dims_eff);
  assign out_free = !out_valid || out_ready;
  assign out_load = (state == ST_OUT) && out_free;
  assign q_pop    = (state == ST_IDLE) && q_valid;

  always_comb begin
    stretch_neg = (sq_root < {1'b0, nrest});
    stretch_mag = stretch_neg ? ({1'b0, nrest} - sq_root) : (sq_root - {1'b0, nrest});
    vel_mag     = svacc_pkg::mag_word(vvel[k]);
  end

  // shared multiplier, product registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQ: begin
        mul_a = d_mag[k];
        mul_b = d_mag[k];
      end
      ST_STR: begin
        mul_a = {1'b0, nstiff};
        mul_b = stretch_mag;
      end
      ST_FMUL: begin
        mul_a = t_mag;
        mul_b = d_mag[k];
      end
      ST_DMUL: begin
        mul_a = {1'b0, vdamp};
        mul_b = vel_mag;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  // square root step: two radicand bits per cycle
  always_comb begin
    sq_rem_sh = {sq_rem[32:0], sq_src[63:62]};
    sq_trial  = {1'b0, sq_root, 2'b01};
    sq_ge     = (sq_rem_sh >= sq_trial);
  end

  always_comb begin
    t_val      = svacc_pkg::sat_word(svacc_pkg::signed_of(str_neg, prod >> FRAC_BITS));
    num_raw    = $signed({{(66-AB){fsum[k][AB-1]}}, fsum[k]})
                 - svacc_pkg::signed_of(vvel[k][W-1], prod >> FRAC_BITS);
    num_cl     = num_raw;
    if (num_raw > LIM) num_cl = LIM;
    else if (num_raw < -LIM) num_cl = -LIM;
    f_val      = $signed({{(66-AB){fsum[k][AB-1]}}, fsum[k]})
                 + svacc_pkg::signed_of(t_neg ^ d_neg[k], div_rsp.quotient);
    q_cap      = (div_rsp.quotient > QCAP) ? QCAP : div_rsp.quotient;
    qs_word    = svacc_pkg::sat_word(svacc_pkg::signed_of(num_neg, q_cap));
    accel_word = svacc_pkg::sat_word($signed({{(66-W){qs_word[W-1]}}, qs_word})
                 + $signed({{(66-W){cfg.ext[k][W-1]}}, cfg.ext[k]}));
  end

  always_comb begin
    div_req.start    = (state == ST_FSTART) || (state == ST_QSTART);
    div_req.dividend = (state == ST_QSTART) ? (num_mag << FRAC_BITS) : prod;
    div_req.divisor  = (state == ST_QSTART) ? {1'b0, vmass} : sq_root;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      vpos       <= '0;
      vvel       <= '0;
      vmass      <= '0;
      vdamp      <= '0;
      fsum       <= '0;
      fault_seen <= 1'b0;
      k          <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur_last <= q_entry.last;
            if (q_entry.kind == svacc_pkg::KIND_VERTEX) begin
              vpos       <= q_entry.pos;
              vvel       <= q_entry.vel;
              vmass      <= q_entry.scalar_one;
              vdamp      <= q_entry.scalar_two;
              fsum       <= '0;
              fault_seen <= 1'b0;
              state      <= ST_LASTCHK;
            end else begin
              npos   <= q_entry.pos;
              nstiff <= q_entry.scalar_one;
              nrest  <= q_entry.scalar_two;
              state  <= ST_DIFF;
            end
          end
        end
        ST_DIFF: begin
          for (int i = 0; i < NA; i++) begin
            logic [W:0]   dd;
            logic [W-1:0] ds;
            dd = {npos[i][W-1], npos[i]} - {vpos[i][W-1], vpos[i]};
            ds = svacc_pkg::sat_word($signed({{(65-W){dd[W]}}, dd}));
            if (i >= int'(dims_eff)) ds = '0;
            d_mag[i] <= svacc_pkg::mag_word(ds);
            d_neg[i] <= ds[W-1];
          end
          sumsq <= '0;
          k     <= '0;
          state <= ST_SQ;
        end
        ST_SQ: begin
          state <= ST_SQACC;
        end
        ST_SQACC: begin
          sumsq <= sumsq + prod;
          if (k == K_LAST) begin
            sq_src  <= sumsq + prod;
            sq_rem  <= '0;
            sq_root <= '0;
            sq_cnt  <= '0;
            state   <= ST_SQRT;
          end else begin
            k     <= k + 1'b1;
            state <= ST_SQ;
          end
        end
        ST_SQRT: begin
          sq_src <= sq_src << 2;
          if (sq_ge) begin
            sq_rem  <= sq_rem_sh - sq_trial;
            sq_root <= {sq_root[W-2:0], 1'b1};
          end else begin
            sq_rem  <= sq_rem_sh;
            sq_root <= {sq_root[W-2:0], 1'b0};
          end
          sq_cnt <= sq_cnt + 1'b1;
          if (sq_cnt == 5'd31) state <= ST_STR;
        end
        ST_STR: begin
          if (sq_root == '0) begin
            fault_seen <= 1'b1;
            state      <= ST_LASTCHK;
          end else begin
            str_neg <= stretch_neg;
            state   <= ST_TSAT;
          end
        end
        ST_TSAT: begin
          t_mag <= svacc_pkg::mag_word(t_val);
          t_neg <= t_val[W-1];
          k     <= '0;
          state <= ST_FMUL;
        end
        ST_FMUL: begin
          state <= ST_FSTART;
        end
        ST_FSTART: begin
          state <= ST_FDIV;
        end
        ST_FDIV: begin
          if (div_rsp.done) begin
            fsum[k] <= svacc_pkg::sat_acc(f_val);
            if (k == K_LAST) begin
              state <= ST_LASTCHK;
            end else begin
              k     <= k + 1'b1;
              state <= ST_FMUL;
            end
          end
        end
        ST_LASTCHK: begin
          k     <= '0;
          state <= cur_last ? ST_DMUL : ST_IDLE;
        end
        ST_DMUL: begin
          state <= ST_NUM;
        end
        ST_NUM: begin
          num_neg  <= num_cl[65];
          num_mag  <= num_cl[65] ? 64'(-num_cl) : num_cl[63:0];
          res_f[k] <= k_active
                      ? svacc_pkg::sat_word($signed({{(66-AB){fsum[k][AB-1]}}, fsum[k]}))
                      : '0;
          if (k_active && vmass != '0) begin
            state <= ST_QSTART;
          end else begin
            res_a[k] <= k_active ? cfg.ext[k] : '0;
            if (k == K_LAST) begin
              state <= ST_OUT;
            end else begin
              k     <= k + 1'b1;
              state <= ST_DMUL;
            end
          end
        end
        ST_QSTART: begin
          state <= ST_QDIV;
        end
        ST_QDIV: begin
          if (div_rsp.done) begin
            res_a[k] <= accel_word;
            if (k == K_LAST) begin
              state <= ST_OUT;
            end else begin
              k     <= k + 1'b1;
              state <= ST_DMUL;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_accel  <= res_a;
            out_force  <= res_f;
            out_fault  <= fault_seen || (vmass == '0);
            fsum       <= '0;
            fault_seen <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/spring_vertex_accel.sv
// Top level of the spring vertex accelerator: config registers, front queue, sequencer.
//
//   channel | handshake            | moves
//   --------+----------------------+--------------------------------------------
//   in      | in_valid / in_ready  | vertex or neighbor item, one per transfer
//   out     | out_valid/out_ready  | accel, summed force and fault, per transfer
//   cfg     | cfg_we               | dimensions, ext_accel_x/y/z by cfg_index
//
// A vertex item loads the vertex state and clears the force sums. A neighbor item
// squares and sums the axis differences, takes the square root (two radicand bits
// a cycle) and divides each axis by the length on the shared divider.
// An item with last_item adds a divide by mass for each active axis with nonzero mass.
// The two-entry input queue takes transfers while the sequencer works; a
// stalled output register holds the sequencer only when the next result is due.
// Reset is synchronous and clears all control and vertex state.
`default_nettype none
module spring_vertex_accel #(
  parameter int FRAC_BITS = svacc_pkg::FRAC_BITS_DEF,
  parameter int MAX_AXES  = svacc_pkg::MAX_AXES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                func,
  input  wire logic [svacc_pkg::WORD_BITS-1:0]     p_x,
  input  wire logic [svacc_pkg::WORD_BITS-1:0]     p_y,
  input  wire logic [svacc_pkg::WORD_BITS-1:0]     p_z,
  input  wire logic [svacc_pkg::WORD_BITS-1:0]     vel_x,
  input  wire logic [svacc_pkg::WORD_BITS-1:0]     vel_y,
  input  wire logic [svacc_pkg::WORD_BITS-1:0]     vel_z,
  input  wire logic [svacc_pkg::SCALAR_BITS-1:0]   scalar_one,
  input  wire logic [svacc_pkg::SCALAR_BITS-1:0]   scalar_two,
  input  wire logic                                last_item,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [svacc_pkg::WORD_BITS-1:0]          accel_x,
  output logic [svacc_pkg::WORD_BITS-1:0]          accel_y,
  output logic [svacc_pkg::WORD_BITS-1:0]          accel_z,
  output logic [svacc_pkg::WORD_BITS-1:0]          force_x,
  output logic [svacc_pkg::WORD_BITS-1:0]          force_y,
  output logic [svacc_pkg::WORD_BITS-1:0]          force_z,
  output logic                                     length_fault,
  input  wire logic                                cfg_we,
  input  wire logic [svacc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [svacc_pkg::WORD_BITS-1:0]     cfg_data
);

  localparam int W  = svacc_pkg::WORD_BITS;
  localparam int NA = svacc_pkg::NUM_AXES;

  svacc_pkg::cfg_t       cfg;
  svacc_pkg::qentry_t    q_entry;
  svacc_pkg::div_req_t   div_req;
  svacc_pkg::div_rsp_t   div_rsp;
  logic                  q_valid;
  logic                  q_pop;
  logic [NA-1:0][W-1:0]  out_accel;
  logic [NA-1:0][W-1:0]  out_force;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dims <= 2'd3;
      cfg.ext  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        svacc_pkg::REG_DIMENSIONS: cfg.dims   <= cfg_data[1:0];
        svacc_pkg::REG_EXT_X:      cfg.ext[0] <= cfg_data;
        svacc_pkg::REG_EXT_Y:      cfg.ext[1] <= cfg_data;
        svacc_pkg::REG_EXT_Z:      cfg.ext[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  svacc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .p_x        (p_x),
    .p_y        (p_y),
    .p_z        (p_z),
    .vel_x      (vel_x),
    .vel_y      (vel_y),
    .vel_z      (vel_z),
    .scalar_one (scalar_one),
    .scalar_two (scalar_two),
    .last_item  (last_item),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop)
  );

  svacc_divu u_divu (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  svacc_back #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_AXES  (MAX_AXES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .cfg       (cfg),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_accel (out_accel),
    .out_force (out_force),
    .out_fault (length_fault)
  );

  assign accel_x = out_accel[0];
  assign accel_y = out_accel[1];
  assign accel_z = out_accel[2];
  assign force_x = out_force[0];
  assign force_y = out_force[1];
  assign force_z = out_force[2];

endmodule
`default_nettype wire

>>> sv/svacc_checker.sv
// Port-level checks for the spring vertex accelerator, bound to the top level.
`default_nettype none
module svacc_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [svacc_pkg::WORD_BITS-1:0]     accel_x,
  input wire logic [svacc_pkg::WORD_BITS-1:0]     accel_y,
  input wire logic [svacc_pkg::WORD_BITS-1:0]     accel_z,
  input wire logic [svacc_pkg::WORD_BITS-1:0]     force_x,
  input wire logic [svacc_pkg::WORD_BITS-1:0]     force_y,
  input wire logic [svacc_pkg::WORD_BITS-1:0]     force_z,
  input wire logic                                length_fault,
  input wire logic                                cfg_we,
  input wire logic [svacc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input wire logic [svacc_pkg::WORD_BITS-1:0]     cfg_data
);

  logic [1:0] dims_shadow;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_shadow <= 2'd3;
    end else if (cfg_we && cfg_index == svacc_pkg::REG_DIMENSIONS) begin
      dims_shadow <= cfg_data[1:0];
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(accel_x) && $stable(force_x) && $stable(length_fault))
    else $error("result payload changed while stalled");

  a_single_axis: assert property (@(posedge clk) disable iff (rst)
    out_valid && (dims_shadow == 2'd0 || dims_shadow == 2'd1)
      |-> accel_y == '0 && accel_z == '0 && force_y == '0 && force_z == '0)
    else $error("unused axis carries a value");

endmodule

bind spring_vertex_accel svacc_checker u_svacc_checker (.*);
`default_nettype wire
